/* design/lbc_pkg.sv */
// Shared types and constants for the lamp blink classifier.
package lbc_pkg;

   localparam int WINDOW_DEFAULT = 8;
   localparam int LAMPS = 3;
   localparam int VIS_WIDTH = 12;
   localparam int MISS_WIDTH = 8;
   localparam int LIMIT_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 8;

   localparam logic [LIMIT_WIDTH-1:0] UNSEEN_FAR_RESET = 8'd17;
   localparam logic [LIMIT_WIDTH-1:0] UNSEEN_NEAR_RESET = 8'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNSEEN_FAR = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNSEEN_NEAR = 2'd1;

   localparam logic OP_OBSERVED = 1'b0;
   localparam logic OP_UNSEEN = 1'b1;

   localparam logic signed [VIS_WIDTH-1:0] VIS_MAX = 12'sd2047;
   localparam logic signed [VIS_WIDTH-1:0] VIS_MIN = -12'sd2048;

   typedef enum logic [1:0] {
      LAMP_UNKNOWN = 2'd0,
      LAMP_OFF = 2'd1,
      LAMP_ON = 2'd2,
      LAMP_BLINK = 2'd3
   } lamp_state_type;

   typedef struct packed {
      lamp_state_type red;
      lamp_state_type yellow;
      lamp_state_type green;
      logic signed [VIS_WIDTH-1:0] visibility;
      logic ready;
   } rsp_type;

endpackage

/* design/lbc_lane.sv */
// One lamp lane: lit window, running majority vote and vote-change count.
module lbc_lane
   import lbc_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic lit,
   output lamp_state_type state_next
);

   localparam int VOTES = 2 * WINDOW;
   localparam int WFW = $clog2(WINDOW + 1);
   localparam int VFW = $clog2(VOTES + 1);
   localparam int CW = $clog2(VOTES);

   // bit 0 is the newest entry
   logic [WINDOW-1:0] win_ff, win_in;
   logic [VOTES-1:0] votes_ff, votes_in;
   logic [WFW-1:0] wfill_ff, wfill_in, ones_ff, ones_in;
   logic [VFW-1:0] vfill_ff, vfill_in;
   logic [CW-1:0] chg_ff, chg_in;
   logic win_full, vote_full, vote;
   logic chg_add, chg_sub;
   logic [WFW:0] twice_ones, fill_ext;

   always_comb begin
      win_full = (wfill_ff == WFW'(WINDOW));
      vote_full = (vfill_ff == VFW'(VOTES));
      win_in = (win_ff << 1) | WINDOW'(lit);
      wfill_in = win_full ? wfill_ff : wfill_ff + WFW'(1);
      vfill_in = vote_full ? vfill_ff : vfill_ff + VFW'(1);
      ones_in = ones_ff + WFW'(lit) - WFW'(win_full & win_ff[WINDOW-1]);

      // sum of +1/-1 over the window is 2*ones - fill
      twice_ones = {ones_in, 1'b0};
      fill_ext = {1'b0, wfill_in};
      priority if (twice_ones > fill_ext) begin
         vote = 1'b1;
      end else if (twice_ones < fill_ext) begin
         vote = 1'b0;
      end else begin
         vote = votes_ff[0];
      end

      votes_in = (votes_ff << 1) | VOTES'(vote);
      chg_add = (vfill_ff != '0) && (votes_ff[0] != vote);
      chg_sub = vote_full && (votes_ff[VOTES-1] != votes_ff[VOTES-2]);
      chg_in = chg_ff + CW'(chg_add) - CW'(chg_sub);

      priority if (vfill_in != VFW'(VOTES)) begin
         state_next = LAMP_UNKNOWN;
      end else if (chg_in > CW'(1)) begin
         state_next = LAMP_BLINK;
      end else if (vote) begin
         state_next = LAMP_ON;
      end else begin
         state_next = LAMP_OFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
         votes_ff <= '0;
         wfill_ff <= '0;
         vfill_ff <= '0;
         ones_ff <= '0;
         chg_ff <= '0;
      end else if (step) begin
         win_ff <= win_in;
         votes_ff <= votes_in;
         wfill_ff <= wfill_in;
         vfill_ff <= vfill_in;
         ones_ff <= ones_in;
         chg_ff <= chg_in;
      end
   end

endmodule

/* design/lbc_merge.sv */
// Merge stage: lamp state register, visibility count, miss count and ready.
module lbc_merge
   import lbc_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic step,
   input  logic operation,
   input  logic laser_overlap,
   input  logic [LIMIT_WIDTH-1:0] limit_far,
   input  logic [LIMIT_WIDTH-1:0] limit_near,
   input  lamp_state_type lane_state [LAMPS],
   output rsp_type result
);

   localparam logic signed [VIS_WIDTH-1:0] READY_LEVEL = VIS_WIDTH'(2 * WINDOW);

   lamp_state_type lamp_ff [LAMPS];
   lamp_state_type lamp_in [LAMPS];
   logic signed [VIS_WIDTH-1:0] vis_ff, vis_in;
   logic [MISS_WIDTH-1:0] miss_ff, miss_in, miss_inc;
   logic ready_ff, ready_in;
   logic drop, all_off, any_unknown, any_changed;

   function automatic logic signed [VIS_WIDTH-1:0] vis_drop(
      input logic signed [VIS_WIDTH-1:0] v);
      logic signed [VIS_WIDTH-1:0] r;
      if (v >= 0) r = -12'sd1;
      else if (v != VIS_MIN) r = v - 12'sd1;
      else r = v;
      return r;
   endfunction

   function automatic logic signed [VIS_WIDTH-1:0] vis_rise(
      input logic signed [VIS_WIDTH-1:0] v);
      logic signed [VIS_WIDTH-1:0] r;
      if (v < 0) r = 12'sd1;
      else if (v != VIS_MAX) r = v + 12'sd1;
      else r = v;
      return r;
   endfunction

   always_comb begin
      all_off = 1'b1;
      any_unknown = 1'b0;
      any_changed = 1'b0;
      for (int i = 0; i < LAMPS; i++) begin
         all_off = all_off && (lane_state[i] == LAMP_OFF);
         any_unknown = any_unknown || (lane_state[i] == LAMP_UNKNOWN);
         any_changed = any_changed ||
            ((lamp_ff[i] != LAMP_UNKNOWN) && (lane_state[i] != lamp_ff[i]));
      end
      miss_inc = (miss_ff == '1) ? miss_ff : miss_ff + MISS_WIDTH'(1);

      lamp_in = lamp_ff;
      vis_in = vis_ff;
      miss_in = miss_ff;
      ready_in = ready_ff;
      drop = 1'b0;
      unique case (operation)
         OP_OBSERVED: begin
            drop = all_off || any_unknown || any_changed;
            lamp_in = lane_state;
            miss_in = '0;
            vis_in = drop ? vis_drop(vis_ff) : vis_rise(vis_ff);
            ready_in = (vis_in >= READY_LEVEL);
         end
         OP_UNSEEN: begin
            miss_in = miss_inc;
            drop = (miss_inc > limit_far) || (!laser_overlap && (miss_inc > limit_near));
            if (drop) begin
               vis_in = vis_drop(vis_ff);
               ready_in = 1'b0;
            end
         end
         default: begin
         end
      endcase

      result.red = lamp_in[0];
      result.yellow = lamp_in[1];
      result.green = lamp_in[2];
      result.visibility = vis_in;
      result.ready = ready_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAMPS; i++) lamp_ff[i] <= LAMP_UNKNOWN;
         vis_ff <= -12'sd1;
         miss_ff <= '0;
         ready_ff <= 1'b0;
      end else if (step) begin
         lamp_ff <= lamp_in;
         vis_ff <= vis_in;
         miss_ff <= miss_in;
         ready_ff <= ready_in;
      end
   end

endmodule

/* design/lamp_blink_classifier_unit.sv */
// Top level of the lamp blink classifier: config, lanes, merge, output buffer.
// Accepted results are written to the output buffer and shown on rsp_ in order.
// Throughput: one item per cycle unless stalled; lanes step only on observed items.
// A two-entry output buffer lets input transfers continue while one result waits.
// Reset (synchronous) clears all lamp history, sets visibility to -1 and
// restores the miss limits to 17 and 2; no clearing pass follows.
module lamp_blink_classifier_unit
   import lbc_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_operation,
   input  logic req_red_lit,
   input  logic req_yellow_lit,
   input  logic req_green_lit,
   input  logic req_laser_overlap,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_red_state,
   output logic [1:0] rsp_yellow_state,
   output logic [1:0] rsp_green_state,
   output logic signed [VIS_WIDTH-1:0] rsp_visibility_level,
   output logic rsp_ready_flag,
   input  logic csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data
);

   logic [LIMIT_WIDTH-1:0] limit_far_ff, limit_near_ff;
   logic accept, lane_step, pop;
   lamp_state_type lane_state [LAMPS];
   logic lane_lit [LAMPS];
   rsp_type result;
   rsp_type buf_ff [2];
   logic rd_ptr_ff, wr_ptr_ff;
   logic [1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_far_ff <= UNSEEN_FAR_RESET;
         limit_near_ff <= UNSEEN_NEAR_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_UNSEEN_FAR: limit_far_ff <= csr_write_data;
            CSR_UNSEEN_NEAR: limit_near_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = (count_ff == 2'd2);
   assign accept = req_valid && !req_stall;
   assign lane_step = accept && (req_operation == OP_OBSERVED);
   assign pop = rsp_valid && !rsp_stall;

   assign lane_lit[0] = req_red_lit;
   assign lane_lit[1] = req_yellow_lit;
   assign lane_lit[2] = req_green_lit;

   for (genvar g = 0; g < LAMPS; g++) begin : g_lane
      lbc_lane #(.WINDOW(WINDOW)) u_lane (
         .clock(clock),
         .reset(reset),
         .step(lane_step),
         .lit(lane_lit[g]),
         .state_next(lane_state[g])
      );
   end

   lbc_merge #(.WINDOW(WINDOW)) u_merge (
      .clock(clock),
      .reset(reset),
      .step(accept),
      .operation(req_operation),
      .laser_overlap(req_laser_overlap),
      .limit_far(limit_far_ff),
      .limit_near(limit_near_ff),
      .lane_state(lane_state),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (accept) buf_ff[wr_ptr_ff] <= result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (accept) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(accept) - 2'(pop);
      end
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_red_state = buf_ff[rd_ptr_ff].red;
   assign rsp_yellow_state = buf_ff[rd_ptr_ff].yellow;
   assign rsp_green_state = buf_ff[rd_ptr_ff].green;
   assign rsp_visibility_level = buf_ff[rd_ptr_ff].visibility;
   assign rsp_ready_flag = buf_ff[rd_ptr_ff].ready;

endmodule

/* design/lbc_checker.sv */
// Port-level checks for the lamp blink classifier, bound to the top level.
module lbc_checker
   import lbc_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [1:0] rsp_red_state,
   input logic signed [VIS_WIDTH-1:0] rsp_visibility_level,
   input logic rsp_ready_flag
);

   localparam logic signed [VIS_WIDTH-1:0] READY_LEVEL = VIS_WIDTH'(2 * WINDOW);

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result pending right after reset");

   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   a_ready_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready_flag) |-> (rsp_visibility_level >= READY_LEVEL))
      else $error("ready flag set below ready level");

   a_vis_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_visibility_level != '0))
      else $error("visibility of zero");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_red_state)
         && $stable(rsp_visibility_level)))
      else $error("stalled result changed");

endmodule

bind lamp_blink_classifier_unit lbc_checker #(.WINDOW(WINDOW)) u_lbc_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_red_state(rsp_red_state),
   .rsp_visibility_level(rsp_visibility_level),
   .rsp_ready_flag(rsp_ready_flag)
);
